// ===== hdl/segment_segment_distance_3d_assert.svh =====
// Assertion macros shared by the segment distance RTL.
// Expects signals clk and rst_n in the scope of use.
`ifndef SEGMENT_SEGMENT_DISTANCE_3D_ASSERT_SVH
`define SEGMENT_SEGMENT_DISTANCE_3D_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define SSD_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ssd assertion failed");

// Condition that must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssd assertion failed");

`endif

// ===== hdl/ssd_pkg.sv =====
// Package for the 3-D segment distance block: widths, constants, item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;
  localparam int COORD_BITS     = 16;
  localparam int DIFF_W         = COORD_BITS + 1;
  localparam int SQ1_W          = 2 * DIFF_W;
  localparam int DOT_W          = SQ1_W + 2;
  localparam int PROD_W         = 2 * DOT_W;
  localparam int WIDE_W         = PROD_W + 2;
  localparam int NUM_W          = PROD_W;
  localparam int THR_W          = 32;
  localparam int FRAC_BITS      = 16;
  localparam int Q_W            = FRAC_BITS + 2;
  localparam int REM_W          = NUM_W + Q_W + 1;
  localparam int DIV_LAT        = Q_W + 1;
  localparam int POS_W          = DIFF_W + Q_W + 3;
  localparam int SQ_W           = 2 * POS_W;
  localparam int RAD_W          = SQ_W + 4;
  localparam int ROOT_W         = RAD_W / 2;
  localparam int DIST_FRAC_BITS = 8;
  localparam int DIST_W         = 25;
  localparam int ROUND_ADD      = 1 << (FRAC_BITS - DIST_FRAC_BITS);
  localparam int ROUND_SHIFT    = FRAC_BITS + 1 - DIST_FRAC_BITS;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(1);
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] u;
    logic [2:0][DIFF_W-1:0] v;
    logic [2:0][DIFF_W-1:0] w;
  } ssd_vec_t;

  typedef struct packed {
    logic [NUM_W-1:0] s_num;
    logic [NUM_W-1:0] s_den;
    logic [NUM_W-1:0] t_num;
    logic [NUM_W-1:0] t_den;
    ssd_vec_t         vec;
  } ssd_item_t;
endpackage
`default_nettype wire

// ===== hdl/segment_segment_distance_3d.sv =====
// Closest distance between two 3-D segments, one pair per cycle unless stalled.
// Throughput: one transaction per cycle when not stalled; set by the fully pipelined divider
// (one quotient bit per stage) and square root (one root bit per stage).
// Reset: synchronous active low; clears all valid bits, queue counts and
// sets the parallel threshold register thr_r to 1.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_segment_distance_3d_assert.svh"
module segment_segment_distance_3d (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ssd_pkg::THR_W-1:0]      cfg_wr_data,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_first_start_x,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_first_start_y,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_first_start_z,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_first_end_x,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_first_end_y,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_first_end_z,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_second_start_x,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_second_start_y,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_second_start_z,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_second_end_x,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_second_end_y,
  input  wire logic signed [ssd_pkg::COORD_BITS-1:0] in_second_end_z,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [ssd_pkg::DIST_W-1:0]          out_distance
);
  import ssd_pkg::*;

  localparam int OUT_DEPTH = 2;

  logic [THR_W-1:0]           thr_r;
  logic [11:0][COORD_BITS-1:0] pts;
  logic                       acc, front_en, f_valid;
  ssd_item_t                  f_item, q_item;
  logic                       q_full, q_empty, q_push, q_pop;
  logic                       back_en, b_valid;
  logic [DIST_W-1:0]          b_dist;
  logic [DIST_W-1:0]          o_mem_r [OUT_DEPTH];
  logic                       o_wr_r, o_rd_r;
  logic [1:0]                 o_cnt_r, o_cnt_nxt;
  logic                       o_push, o_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  assign pts = {in_second_end_z,   in_second_end_y,   in_second_end_x,
                in_second_start_z, in_second_start_y, in_second_start_x,
                in_first_end_z,    in_first_end_y,    in_first_end_x,
                in_first_start_z,  in_first_start_y,  in_first_start_x};

  // Front stalls only when its last stage cannot drain into the queue
  assign front_en = !(f_valid && q_full);
  assign full     = !front_en;
  assign acc      = push && !full;
  assign q_push   = f_valid && !q_full;

  ssd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (front_en),
    .acc        (acc),
    .pts        (pts),
    .thr        (thr_r),
    .item_valid (f_valid),
    .item       (f_item)
  );

  ssd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (f_item),
    .pop   (q_pop),
    .dout  (q_item),
    .full  (q_full),
    .empty (q_empty)
  );

  assign back_en = !(b_valid && (o_cnt_r == 2'(OUT_DEPTH)));
  assign q_pop   = back_en && !q_empty;

  ssd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (back_en),
    .in_valid   (!q_empty),
    .item       (q_item),
    .thr        (thr_r),
    .last_valid (b_valid),
    .distance   (b_dist)
  );

  // Two-entry output buffer
  assign o_push = b_valid && back_en;
  assign o_pop  = pop && !empty;

  always_comb begin
    o_cnt_nxt = o_cnt_r;
    if (o_push && !o_pop) begin
      o_cnt_nxt = o_cnt_r + 1'b1;
    end else if (o_pop && !o_push) begin
      o_cnt_nxt = o_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_wr_r  <= 1'b0;
      o_rd_r  <= 1'b0;
      o_cnt_r <= '0;
    end else begin
      o_cnt_r <= o_cnt_nxt;
      if (o_push) begin
        o_wr_r <= !o_wr_r;
      end
      if (o_pop) begin
        o_rd_r <= !o_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      o_mem_r[o_wr_r] <= b_dist;
    end
  end

  assign empty        = (o_cnt_r == '0);
  assign out_distance = o_mem_r[o_rd_r];

  `SSD_ASSERT(a_out_cnt_range, o_cnt_r <= 2'(OUT_DEPTH))
  `SSD_ASSERT(a_out_no_overflow, !(o_push && !o_pop && (o_cnt_r == 2'(OUT_DEPTH))))
  `SSD_ASSERT_NEXT(a_back_stall_hold, b_valid && !back_en, b_valid)
  `SSD_ASSERT_NEXT(a_front_stall_hold, f_valid && !front_en, f_valid)
endmodule
`default_nettype wire

// ===== hdl/ssd_front.sv =====
// Front end: difference vectors, dot products, determinant and the clamping
// decisions for both line parameters. Uses ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssd_front (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     en,
  input  wire logic                                     acc,
  input  wire logic [11:0][ssd_pkg::COORD_BITS-1:0]     pts,
  input  wire logic [ssd_pkg::THR_W-1:0]                thr,
  output logic                                          item_valid,
  output ssd_pkg::ssd_item_t                            item
);
  import ssd_pkg::*;

  function automatic diff_t sx(input logic [COORD_BITS-1:0] x);
    return {x[COORD_BITS-1], x};
  endfunction

  logic [6:0] vld_r;
  ssd_vec_t   vec_in;
  ssd_vec_t   vec_r [7];

  logic signed [SQ1_W-1:0]  uu_r [3], uv_r [3], vv_r [3], uw_r [3], vw_r [3];
  logic signed [DOT_W-1:0]  a3_r, b3_r, c3_r, d3_r, e3_r;
  logic signed [PROD_W-1:0] ac4_r, bb4_r, be4_r, cd4_r, ae4_r, bd4_r;
  logic signed [DOT_W-1:0]  a4_r, b4_r, c4_r, d4_r, e4_r;
  logic signed [WIDE_W-1:0] dt5_r, sn5_r, tn5_r;
  logic signed [DOT_W-1:0]  a5_r, b5_r, c5_r, d5_r, e5_r;
  logic signed [WIDE_W-1:0] sn6_r, sd6_r, tn6_r, td6_r;
  logic signed [DOT_W-1:0]  a6_r, b6_r, d6_r;
  logic signed [WIDE_W-1:0] sn7_r, sd7_r, tn7_r, td7_r;

  logic signed [WIDE_W-1:0] thr_w;
  logic signed [WIDE_W-1:0] sn_a, sd_a, tn_a, td_a;
  logic signed [WIDE_W-1:0] sn_b, sd_b, tn_b, x_b, a_w;
  logic                     fix_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec_in.u[i] = sx(pts[3+i]) - sx(pts[i]);
      vec_in.v[i] = sx(pts[9+i]) - sx(pts[6+i]);
      vec_in.w[i] = sx(pts[i])   - sx(pts[6+i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], acc};
    end
  end

  // Parallel test and s clamp
  assign thr_w = $signed({{(WIDE_W-THR_W){1'b0}}, thr});

  always_comb begin
    if (dt5_r < thr_w) begin
      sn_a = '0;
      sd_a = WIDE_W'(1);
      tn_a = WIDE_W'(e5_r);
      td_a = WIDE_W'(c5_r);
    end else begin
      sd_a = dt5_r;
      td_a = dt5_r;
      sn_a = sn5_r;
      tn_a = tn5_r;
      if (sn5_r[WIDE_W-1]) begin
        sn_a = '0;
        tn_a = WIDE_W'(e5_r);
        td_a = WIDE_W'(c5_r);
      end else if (dt5_r < sn5_r) begin
        sn_a = dt5_r;
        tn_a = WIDE_W'(e5_r) + WIDE_W'(b5_r);
        td_a = WIDE_W'(c5_r);
      end
    end
  end

  // t clamp, which may re-solve s on the edge
  assign a_w = WIDE_W'(a6_r);

  always_comb begin
    sn_b  = sn6_r;
    sd_b  = sd6_r;
    tn_b  = tn6_r;
    fix_b = 1'b0;
    x_b   = -WIDE_W'(d6_r);
    if (tn6_r[WIDE_W-1]) begin
      tn_b  = '0;
      fix_b = 1'b1;
    end else if (td6_r < tn6_r) begin
      tn_b  = td6_r;
      fix_b = 1'b1;
      x_b   = WIDE_W'(b6_r) - WIDE_W'(d6_r);
    end
    if (fix_b) begin
      if (x_b[WIDE_W-1]) begin
        sn_b = '0;
      end else if (a_w < x_b) begin
        sn_b = sd6_r;
      end else begin
        sn_b = x_b;
        sd_b = a_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r[0] <= vec_in;
      for (int k = 1; k < 7; k++) begin
        vec_r[k] <= vec_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        uu_r[i] <= $signed(vec_r[0].u[i]) * $signed(vec_r[0].u[i]);
        uv_r[i] <= $signed(vec_r[0].u[i]) * $signed(vec_r[0].v[i]);
        vv_r[i] <= $signed(vec_r[0].v[i]) * $signed(vec_r[0].v[i]);
        uw_r[i] <= $signed(vec_r[0].u[i]) * $signed(vec_r[0].w[i]);
        vw_r[i] <= $signed(vec_r[0].v[i]) * $signed(vec_r[0].w[i]);
      end
      a3_r <= DOT_W'(uu_r[0]) + DOT_W'(uu_r[1]) + DOT_W'(uu_r[2]);
      b3_r <= DOT_W'(uv_r[0]) + DOT_W'(uv_r[1]) + DOT_W'(uv_r[2]);
      c3_r <= DOT_W'(vv_r[0]) + DOT_W'(vv_r[1]) + DOT_W'(vv_r[2]);
      d3_r <= DOT_W'(uw_r[0]) + DOT_W'(uw_r[1]) + DOT_W'(uw_r[2]);
      e3_r <= DOT_W'(vw_r[0]) + DOT_W'(vw_r[1]) + DOT_W'(vw_r[2]);

      ac4_r <= a3_r * c3_r;
      bb4_r <= b3_r * b3_r;
      be4_r <= b3_r * e3_r;
      cd4_r <= c3_r * d3_r;
      ae4_r <= a3_r * e3_r;
      bd4_r <= b3_r * d3_r;
      a4_r  <= a3_r;
      b4_r  <= b3_r;
      c4_r  <= c3_r;
      d4_r  <= d3_r;
      e4_r  <= e3_r;

      dt5_r <= WIDE_W'(ac4_r) - WIDE_W'(bb4_r);
      sn5_r <= WIDE_W'(be4_r) - WIDE_W'(cd4_r);
      tn5_r <= WIDE_W'(ae4_r) - WIDE_W'(bd4_r);
      a5_r  <= a4_r;
      b5_r  <= b4_r;
      c5_r  <= c4_r;
      d5_r  <= d4_r;
      e5_r  <= e4_r;

      sn6_r <= sn_a;
      sd6_r <= sd_a;
      tn6_r <= tn_a;
      td6_r <= td_a;
      a6_r  <= a5_r;
      b6_r  <= b5_r;
      d6_r  <= d5_r;

      sn7_r <= sn_b;
      sd7_r <= sd_b;
      tn7_r <= tn_b;
      td7_r <= td6_r;
    end
  end

  // Final numerators and denominators are nonnegative and bounded by the largest of a*c, a, c and 1
  assign item_valid  = vld_r[6];
  assign item.s_num  = sn7_r[NUM_W-1:0];
  assign item.s_den  = sd7_r[NUM_W-1:0];
  assign item.t_num  = tn7_r[NUM_W-1:0];
  assign item.t_den  = td7_r[NUM_W-1:0];
  assign item.vec    = vec_r[6];
endmodule
`default_nettype wire

// ===== hdl/ssd_queue.sv =====
// Short queue between front and back end, holding classified items.
// Uses ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ssd_pkg::ssd_item_t din,
  input  wire logic               pop,
  output ssd_pkg::ssd_item_t      dout,
  output logic                    full,
  output logic                    empty
);
  import ssd_pkg::*;

  ssd_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_r];
  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
endmodule
`default_nettype wire

// ===== hdl/ssd_div.sv =====
// Pipelined restoring divider: parameter in 1/65536 units, rounded half up.
// One quotient bit per stage; zero when den is zero or num is below thr. Uses ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssd_div (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [ssd_pkg::NUM_W-1:0] num,
  input  wire logic [ssd_pkg::NUM_W-1:0] den,
  input  wire logic [ssd_pkg::THR_W-1:0] thr,
  output logic [ssd_pkg::Q_W-1:0]        quo
);
  import ssd_pkg::*;

  logic [REM_W-1:0] rem_r [Q_W+1];
  logic [REM_W-1:0] dd_r  [Q_W+1];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  logic             zero_r [Q_W+1];

  // rem starts at num*2^17 + den, divisor is 2*den
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= (REM_W'(num) << (FRAC_BITS + 1)) + REM_W'(den);
      dd_r[0]   <= REM_W'(den) << 1;
      q_r[0]    <= '0;
      zero_r[0] <= (den == '0) || (num < NUM_W'(thr));
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int BIT = Q_W - 1 - k;
    logic [REM_W-1:0] trial;
    assign trial = dd_r[k] << BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        dd_r[k+1]   <= dd_r[k];
        zero_r[k+1] <= zero_r[k];
        if (rem_r[k] >= trial) begin
          rem_r[k+1] <= rem_r[k] - trial;
          q_r[k+1]   <= q_r[k] | (Q_W'(1) << BIT);
        end else begin
          rem_r[k+1] <= rem_r[k];
          q_r[k+1]   <= q_r[k];
        end
      end
    end
  end

  assign quo = zero_r[Q_W] ? '0 : q_r[Q_W];
endmodule
`default_nettype wire

// ===== hdl/ssd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage (floor).
// Uses ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssd_sqrt (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [ssd_pkg::RAD_W-1:0]  rad,
  output logic [ssd_pkg::ROOT_W-1:0]      root
);
  import ssd_pkg::*;

  localparam int SR_W = ROOT_W + 3;

  logic [RAD_W-1:0]  n_r    [ROOT_W];
  logic [SR_W-1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RAD_W-1:0]  n_in;
    logic [SR_W-1:0]   rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;

    if (k == 0) begin : g_first
      assign n_in    = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // remainder never exceeds 2*root, so its top two bits are free
    assign rem_sh = {rem_in[SR_W-3:0], n_in[RAD_W-1 -: 2]};
    assign trial  = SR_W'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_in << 2;
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];
endmodule
`default_nettype wire

// ===== hdl/ssd_back.sv =====
// Back end: parameter division, offset vector, squared length, root, rounding and saturation.
// Uses ssd_pkg, ssd_div and ssd_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module ssd_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire ssd_pkg::ssd_item_t        item,
  input  wire logic [ssd_pkg::THR_W-1:0] thr,
  output logic                           last_valid,
  output logic [ssd_pkg::DIST_W-1:0]     distance
);
  import ssd_pkg::*;

  localparam int BACK_LAT = DIV_LAT + 5 + ROOT_W;

  logic [BACK_LAT-1:0]     vld_r;
  ssd_vec_t                side_r [DIV_LAT];
  logic [Q_W-1:0]          sc, tc;
  logic signed [POS_W-1:0] su_r [3], tv_r [3], ws_r [3], q_r [3];
  logic signed [SQ_W-1:0]  sq_r [3];
  logic [RAD_W-1:0]        rad_r;
  logic [ROOT_W-1:0]       root;
  logic [ROOT_W:0]         rnd;
  logic [DIST_W-1:0]       dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[BACK_LAT-2:0], in_valid};
    end
  end

  ssd_div u_div_s (
    .clk (clk),
    .en  (en),
    .num (item.s_num),
    .den (item.s_den),
    .thr (thr),
    .quo (sc)
  );

  ssd_div u_div_t (
    .clk (clk),
    .en  (en),
    .num (item.t_num),
    .den (item.t_den),
    .thr (thr),
    .quo (tc)
  );

  ssd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_r),
    .root (root)
  );

  assign rnd = ({1'b0, root} + (ROOT_W+1)'(ROUND_ADD)) >> ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= item.vec;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
      // offset = w*2^16 + sc*u - tc*v, exact in 1/65536 units
      for (int i = 0; i < 3; i++) begin
        su_r[i] <= $signed({1'b0, sc}) * $signed(side_r[DIV_LAT-1].u[i]);
        tv_r[i] <= $signed({1'b0, tc}) * $signed(side_r[DIV_LAT-1].v[i]);
        ws_r[i] <= POS_W'($signed(side_r[DIV_LAT-1].w[i])) <<< FRAC_BITS;
        q_r[i]  <= ws_r[i] + su_r[i] - tv_r[i];
        sq_r[i] <= q_r[i] * q_r[i];
      end
      rad_r <= (RAD_W'($unsigned(sq_r[0])) + RAD_W'($unsigned(sq_r[1]))
              + RAD_W'($unsigned(sq_r[2]))) << 2;
      if (rnd > (ROOT_W+1)'(DIST_MAX)) begin
        dist_r <= DIST_MAX;
      end else begin
        dist_r <= rnd[DIST_W-1:0];
      end
    end
  end

  assign last_valid = vld_r[BACK_LAT-1];
  assign distance   = dist_r;
endmodule
`default_nettype wire

// ===== verif/tb_segment_segment_distance_3d.sv =====
// Self-checking testbench for segment_segment_distance_3d: random and directed segment pairs,
// predicted distances checked in order. Depends on ssd_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_segment_segment_distance_3d;
  import ssd_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [COORD_BITS-1:0] pair_t [12];

  // Computes expected distances and compares them, oldest first.
  class segment_distance_check;
    logic [THR_W-1:0]  threshold;
    logic [DIST_W-1:0] expected_dist [$];
    int                mismatches;

    function new();
      threshold  = THR_RESET;
      mismatches = 0;
    endfunction

    function automatic longint frac16(wide_t num, wide_t den, wide_t thr);
      wide_t q;
      if (den == 0 || num < thr || num < 0 || den < 0) return 0;
      q = ((num <<< 17) + den) / (den <<< 1);
      return longint'(q);
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] n);
      logic [127:0] res, bitv;
      res  = 0;
      bitv = 128'd1 << 126;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic logic [DIST_W-1:0] predict(pair_t p);
      longint u [3], v [3], w [3];
      longint a, b, c, d, e, sc, tc, q;
      wide_t thr, dd, s_num, s_den, t_num, t_den, x, sum;
      logic [127:0] m, dist_v;
      a = 0; b = 0; c = 0; d = 0; e = 0;
      for (int i = 0; i < 3; i++) begin
        u[i] = longint'(p[3 + i]) - longint'(p[i]);
        v[i] = longint'(p[9 + i]) - longint'(p[6 + i]);
        w[i] = longint'(p[i]) - longint'(p[6 + i]);
        a += u[i] * u[i];
        b += u[i] * v[i];
        c += v[i] * v[i];
        d += u[i] * w[i];
        e += v[i] * w[i];
      end
      thr = 0;
      thr[THR_W-1:0] = threshold;
      dd = wide_t'(a) * wide_t'(c) - wide_t'(b) * wide_t'(b);
      if (dd < thr) begin
        // lines treated as parallel
        s_num = 0; s_den = 1; t_num = e; t_den = c;
      end else begin
        s_den = dd; t_den = dd;
        s_num = wide_t'(b) * wide_t'(e) - wide_t'(c) * wide_t'(d);
        t_num = wide_t'(a) * wide_t'(e) - wide_t'(b) * wide_t'(d);
        if (s_num < 0) begin
          s_num = 0; t_num = e; t_den = c;
        end else if (s_den < s_num) begin
          s_num = s_den; t_num = e + b; t_den = c;
        end
      end
      if (t_num < 0 || t_den < t_num) begin
        if (t_num < 0) begin
          t_num = 0;
          x = -d;
        end else begin
          t_num = t_den;
          x = b - d;
        end
        if (x < 0) s_num = 0;
        else if (wide_t'(a) < x) s_num = s_den;
        else begin
          s_num = x;
          s_den = a;
        end
      end
      sc  = frac16(s_num, s_den, thr);
      tc  = frac16(t_num, t_den, thr);
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        q = w[i] * 65536 + sc * u[i] - tc * v[i];
        sum += wide_t'(q) * wide_t'(q);
      end
      m      = isqrt(sum << 2);
      dist_v = (m + (128'd1 << (FRAC_BITS - DIST_FRAC_BITS))) >> ROUND_SHIFT;
      if (dist_v > DIST_MAX) dist_v = DIST_MAX;
      return dist_v[DIST_W-1:0];
    endfunction

    function void note_pair(pair_t p);
      expected_dist.push_back(predict(p));
    endfunction

    function void check_distance(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (expected_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance %0d", got);
        return;
      end
      want = expected_dist.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("distance: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;
  logic push, pop;
  logic full, empty;
  logic [DIST_W-1:0] out_distance;
  pair_t cur;

  int send_idle, recv_idle, hold_cycles, quiet_cycles;
  segment_distance_check sb = new();

  segment_segment_distance_3d u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .push             (push),
    .full             (full),
    .in_first_start_x (cur[0]),
    .in_first_start_y (cur[1]),
    .in_first_start_z (cur[2]),
    .in_first_end_x   (cur[3]),
    .in_first_end_y   (cur[4]),
    .in_first_end_z   (cur[5]),
    .in_second_start_x(cur[6]),
    .in_second_start_y(cur[7]),
    .in_second_start_z(cur[8]),
    .in_second_end_x  (cur[9]),
    .in_second_end_y  (cur[10]),
    .in_second_end_z  (cur[11]),
    .empty            (empty),
    .pop              (pop),
    .out_distance     (out_distance)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // transaction monitor: RTL updates land after this reads
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) sb.note_pair(cur);
      if (pop && !empty) sb.check_distance(out_distance);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 3000) begin
        $display("segment_segment_distance_3d: mismatch");
        $finish;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      pop = 1'b0;
      hold_cycles--;
    end else begin
      pop = ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic send_pair(pair_t p);
    bit taken;
    while ($urandom_range(0, 99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    cur  = p;
    push = 1'b1;
    do begin
      @(posedge clk);
      taken = !full;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] val);
    push = 1'b0;
    while (sb.expected_dist.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = val;
    sb.threshold = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic int small_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic random_pair(output pair_t p);
    int kind, k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) p[i] = COORD_BITS'($urandom);
    case (kind)
      4, 5: begin
        for (int i = 0; i < 12; i++) p[i] = COORD_BITS'(small_coord(32));
      end
      6: begin
        // second segment along a multiple of the first direction
        k = small_coord(3);
        for (int i = 0; i < 3; i++) begin
          p[i]     = COORD_BITS'(small_coord(1000));
          p[3 + i] = COORD_BITS'(p[i] + small_coord(200));
          p[6 + i] = COORD_BITS'(small_coord(1000));
          p[9 + i] = COORD_BITS'(p[6 + i] + k * (p[3 + i] - p[i]));
        end
      end
      7: begin
        for (int i = 0; i < 3; i++) p[3 + i] = p[i];
        if ($urandom_range(0, 1)) for (int i = 0; i < 3; i++) p[9 + i] = p[6 + i];
      end
      8: begin
        for (int i = 0; i < 3; i++) p[6 + i] = p[3 + i];
      end
      default: ;
    endcase
  endtask

  task automatic random_phase(int count);
    pair_t p;
    for (int n = 0; n < count; n++) begin
      random_pair(p);
      send_pair(p);
    end
    push = 1'b0;
  endtask

  initial begin
    pair_t directed [$];
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    push        = 1'b0;
    pop         = 1'b0;
    hold_cycles = 0;
    quiet_cycles = 0;
    send_idle   = 15;
    recv_idle   = 48;
    for (int i = 0; i < 12; i++) cur[i] = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{32767, 32767, 32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767, 32767, 32767});
    directed.push_back('{-32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768, -32768, -32768});
    // two diagonals of the full cube
    directed.push_back('{-32768, -32768, -32768, 32767, 32767, 32767,
                         32767, -32768, 32767, -32768, 32767, -32768});
    // opposite corners, both segments points
    directed.push_back('{-32768, -32768, -32768, -32768, -32768, -32768,
                         32767, 32767, 32767, 32767, 32767, 32767});
    directed.push_back('{-32768, -32768, -32768, 32767, -32768, -32768,
                         32767, 32767, 32767, -32768, 32767, 32767});
    directed.push_back('{0, 0, 0, 10, 0, 0, 0, 5, 0, 10, 5, 0});
    directed.push_back('{0, 0, 0, 10, 0, 0, 20, 3, 0, 30, 3, 0});
    directed.push_back('{0, 0, 0, 10, 0, 0, -30, 3, 0, -20, 3, 0});
    directed.push_back('{0, 0, 0, 10, 0, 0, 30, 3, 0, 20, 3, 0});
    directed.push_back('{-5, 0, 0, 5, 0, 0, 0, -5, 3, 0, 5, 3});
    directed.push_back('{0, 0, 0, 10, 0, 0, 15, -5, 2, 15, 5, 2});
    directed.push_back('{0, 0, 0, 10, 0, 0, 3, 2, 5, 3, 9, 5});
    directed.push_back('{0, 0, 0, 10, 0, 0, 3, -9, 5, 3, -2, 5});
    directed.push_back('{-7, -7, 4, 12, 3, 1, 0, 0, 0, 1, 2, 3});
    directed.push_back('{1, 2, 3, 1, 2, 3, 4, 5, 6, 4, 5, 6});
    directed.push_back('{1, 2, 3, 1, 2, 3, -4, 5, 6, 9, -5, 6});
    directed.push_back('{-4, 5, 6, 9, -5, 6, 1, 2, 3, 1, 2, 3});
    directed.push_back('{21845, -21846, 21845, -21846, 21845, -21846,
                         -21846, 21845, -21846, 21845, -21846, 21845});
    directed.push_back('{0, 0, 0, 1, 1, 1, 0, 0, 1, 1, 1, 2});
    directed.push_back('{-32768, 0, 32767, 32767, 0, -32768, 0, -32768, 0, 0, 32767, 0});
    foreach (directed[i]) send_pair(directed[i]);

    write_threshold('0);
    random_phase(200);

    send_idle = 48;
    recv_idle = 15;
    write_threshold('1);
    random_phase(200);

    send_idle = 0;
    recv_idle = 0;
    write_threshold($urandom);
    hold_cycles = 400;
    random_phase(200);

    write_threshold(THR_W'(1) << $urandom_range(0, 31));
    random_phase(100);
    write_threshold(THR_RESET);
    random_phase(100);

    while (sb.expected_dist.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("segment_segment_distance_3d: match");
    end else begin
      $display("segment_segment_distance_3d: mismatch");
    end
    $finish;
  end
endmodule
